FILE: rtl/egd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// egd_pkg
// Types and constants shared by the gradient magnitude and direction block.
// ----------------------------------------------------------------------------
package egd_pkg;

   localparam int PIX_W       = 20;
   localparam int GRAD_W      = 27;
   localparam int ABS_W       = 26;
   localparam int SQ_W        = 52;
   localparam int MAG_W       = 26;
   localparam int ROOT_STEPS  = 26;

   // Register indexes on the configuration port.
   localparam logic [1:0] REG_LINE_WIDTH   = 2'd0;
   localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;
   localparam logic [1:0] REG_OPERATOR     = 2'd2;
   localparam logic [1:0] REG_DIR_ENABLE   = 2'd3;

   // Gradient operators.
   localparam logic [1:0] OP_DIFF    = 2'd0;
   localparam logic [1:0] OP_PREWITT = 2'd1;
   localparam logic [1:0] OP_SOBEL   = 2'd2;
   localparam logic [1:0] OP_SCHARR  = 2'd3;

   // Direction bins.
   localparam logic [1:0] BIN_HORIZ = 2'd0;
   localparam logic [1:0] BIN_45    = 2'd1;
   localparam logic [1:0] BIN_VERT  = 2'd2;
   localparam logic [1:0] BIN_135   = 2'd3;

   // Which neighbourhood of the window a result is taken from.
   // Bit 0 set: the right column is repeated; bit 1 set: the bottom row is.
   localparam logic [1:0] KIND_CENTRE      = 2'd0;
   localparam logic [1:0] KIND_RIGHT_EDGE  = 2'd1;
   localparam logic [1:0] KIND_BOTTOM      = 2'd2;
   localparam logic [1:0] KIND_CORNER      = 2'd3;

   typedef logic [PIX_W-1:0] pix_type;
   typedef pix_type [8:0] win_type;

   typedef struct packed {
      logic [12:0] line_width;
      logic [15:0] frame_height;
      logic [1:0]  gradient_operator;
      logic        direction_enable;
   } cfg_type;

   typedef struct packed {
      logic       valid;
      logic       last;
      logic [1:0] kind;
   } issue_type;

   typedef struct packed {
      logic            valid;
      logic            last;
      logic [1:0]      dir;
      logic [SQ_W-1:0] rem;
      logic [SQ_W-1:0] res;
   } cell_type;

endpackage

FILE: rtl/egd_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// egd_req_if
// Pixel input channel: one blurred pixel per beat.
// ----------------------------------------------------------------------------
interface egd_req_if;
   logic        valid;
   logic        ready;
   logic [19:0] pixel_value;

   modport source (output valid, output pixel_value, input ready);
   modport sink   (input valid, input pixel_value, output ready);
endinterface

FILE: rtl/egd_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// egd_rsp_if
// Result channel: one gradient magnitude and direction per beat.
// ----------------------------------------------------------------------------
interface egd_rsp_if;
   logic        valid;
   logic        ready;
   logic [25:0] magnitude;
   logic [1:0]  direction_bin;
   logic        last_in_run;

   modport source (output valid, output magnitude, output direction_bin,
                   output last_in_run, input ready);
   modport sink   (input valid, input magnitude, input direction_bin,
                   input last_in_run, output ready);
endinterface

FILE: rtl/egd_window.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// egd_window
// Line stores, 3x3 window, raster counters and the result sequencer.
// ----------------------------------------------------------------------------
module egd_window #(
   parameter int MAX_WIDTH = 4096
) (
   input  logic                clock,
   input  logic                reset,
   input  egd_pkg::cfg_type    cfg,
   input  logic                in_valid,
   output logic                in_ready,
   input  egd_pkg::pix_type    in_pixel,
   input  logic                advance,
   output egd_pkg::issue_type  issue,
   output egd_pkg::win_type    window
);
   import egd_pkg::*;

   localparam int CW = $clog2(MAX_WIDTH);
   localparam logic [CW-1:0] X_MAX = CW'(MAX_WIDTH - 1);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_READ = 2'd1;
   localparam logic [1:0] S_UPD  = 2'd2;
   localparam logic [1:0] S_EMIT = 2'd3;

   logic [1:0]    state_ff, state_in;
   logic [CW-1:0] col_ff, col_in;
   logic [15:0]   row_ff, row_in;
   logic [3:0]    mask_ff, mask_in;
   pix_type       pix_ff;
   win_type       win_ff, win_in;
   pix_type       older_mem [MAX_WIDTH];
   pix_type       newer_mem [MAX_WIDTH];
   pix_type       rd_old_ff, rd_new_ff;

   logic [CW-1:0] x_c;
   logic [31:0]   w_eff;
   logic [15:0]   h_eff;
   logic          at_end, at_last, wr_en;
   pix_type       v;
   logic [1:0]    kind;
   logic [3:0]    mask_left;

   always_comb begin
      x_c = (col_ff >= X_MAX) ? X_MAX : col_ff;
      if (cfg.line_width == 13'd0) begin
         w_eff = 32'd1;
      end else if (32'(cfg.line_width) > 32'(MAX_WIDTH)) begin
         w_eff = 32'(MAX_WIDTH);
      end else begin
         w_eff = 32'(cfg.line_width);
      end
      h_eff   = (cfg.frame_height < 16'd2) ? 16'd2 : cfg.frame_height;
      at_end  = 32'(x_c) >= (w_eff - 32'd1);
      at_last = row_ff >= (h_eff - 16'd1);
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         newer_mem[x_c] <= pix_ff;
         if (row_ff != 16'd0) begin
            older_mem[x_c] <= rd_new_ff;
         end
      end
      rd_old_ff <= older_mem[x_c];
      rd_new_ff <= newer_mem[x_c];
   end

   always_comb begin
      kind = mask_ff[0] ? KIND_CENTRE : mask_ff[1] ? KIND_RIGHT_EDGE :
             mask_ff[2] ? KIND_BOTTOM : KIND_CORNER;
      mask_left = mask_ff & ~(4'd1 << kind);
   end

   always_comb begin
      state_in = state_ff;
      col_in   = col_ff;
      row_in   = row_ff;
      mask_in  = mask_ff;
      win_in   = win_ff;
      wr_en    = 1'b0;
      v        = '0;
      issue    = '0;
      case (state_ff)
         S_IDLE: begin
            if (in_valid) begin
               state_in = S_READ;
            end
         end
         S_READ: state_in = S_UPD;
         S_UPD: begin
            wr_en = 1'b1;
            if (row_ff != 16'd0) begin
               for (int k = 0; k < 3; k++) begin
                  v = (k == 0) ? ((row_ff == 16'd1) ? rd_new_ff : rd_old_ff) :
                      (k == 1) ? rd_new_ff : pix_ff;
                  if (x_c == '0) begin
                     win_in[k*3]   = v;
                     win_in[k*3+1] = v;
                  end else begin
                     win_in[k*3]   = win_ff[k*3+1];
                     win_in[k*3+1] = win_ff[k*3+2];
                  end
                  win_in[k*3+2] = v;
               end
               mask_in = {at_last & at_end, at_last & (x_c != '0), at_end, x_c != '0};
            end else begin
               mask_in = 4'd0;
            end
            if (at_end) begin
               col_in = '0;
               row_in = (row_ff != 16'd0 && at_last) ? 16'd0 : row_ff + 16'd1;
            end else begin
               col_in = x_c + CW'(1);
            end
            state_in = (row_ff != 16'd0 && mask_in != 4'd0) ? S_EMIT : S_IDLE;
         end
         S_EMIT: begin
            if (advance) begin
               issue.valid = 1'b1;
               issue.last  = (mask_left == 4'd0);
               issue.kind  = kind;
               mask_in     = mask_left;
               if (mask_left == 4'd0) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         col_ff   <= '0;
         row_ff   <= '0;
         mask_ff  <= '0;
         win_ff   <= '0;
      end else begin
         state_ff <= state_in;
         col_ff   <= col_in;
         row_ff   <= row_in;
         mask_ff  <= mask_in;
         win_ff   <= win_in;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE && in_valid) begin
         pix_ff <= in_pixel;
      end
   end

   assign in_ready = (state_ff == S_IDLE);
   assign window   = win_ff;

endmodule

FILE: rtl/egd_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// egd_front
// Gradient operator, squares and direction bin, feeding the root chain.
// ----------------------------------------------------------------------------
module egd_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  egd_pkg::cfg_type    cfg,
   input  egd_pkg::issue_type  issue,
   input  egd_pkg::win_type    window,
   output egd_pkg::cell_type   head
);
   import egd_pkg::*;

   typedef logic signed [GRAD_W-1:0] grad_type;

   // Stage A: gx and gy.
   logic     a_valid_ff, a_last_ff;
   grad_type gx_ff, gy_ff;
   // Stage B: folded magnitudes.
   logic             b_valid_ff, b_last_ff, b_zero_ff, b_neg_ff, b_gt_ff;
   logic [ABS_W-1:0] ax_ff, ay_ff, d_ff;
   logic [ABS_W:0]   s_ff;
   // Stage C: products.
   logic                c_valid_ff, c_last_ff, c_zero_ff, c_neg_ff, c_gt_ff;
   logic [SQ_W-1:0]     ax2_ff, ay2_ff, d2_ff;
   logic [2*ABS_W+1:0]  s2_ff;
   cell_type            head_ff;

   grad_type tl, tc, tr, ml, mr, bl, bc, br, gx_in, gy_in, fx, fy;
   int unsigned ra, rb, cl, cc;
   logic [SQ_W:0] two;
   logic near_axis, steep;
   logic [1:0] bin;

   function automatic grad_type ext(input pix_type p);
      ext = $signed({{(GRAD_W-PIX_W){1'b0}}, p});
   endfunction

   always_comb begin
      ra = issue.kind[1] ? 1 : 0;
      rb = issue.kind[1] ? 2 : 1;
      cl = issue.kind[0] ? 1 : 0;
      cc = issue.kind[0] ? 2 : 1;
      tl = ext(window[ra*3+cl]);
      tc = ext(window[ra*3+cc]);
      tr = ext(window[ra*3+2]);
      ml = ext(window[rb*3+cl]);
      mr = ext(window[rb*3+2]);
      bl = ext(window[6+cl]);
      bc = ext(window[6+cc]);
      br = ext(window[8]);
      case (cfg.gradient_operator)
         OP_DIFF: begin
            gx_in = (mr - ml) <<< 1;
            gy_in = (tc - bc) <<< 1;
         end
         OP_PREWITT: begin
            gx_in = (tr + mr + br) - (tl + ml + bl);
            gy_in = (tl + tc + tr) - (bl + bc + br);
         end
         OP_SOBEL: begin
            gx_in = ((tr + (mr <<< 1) + br) - (tl + (ml <<< 1) + bl)) <<< 1;
            gy_in = ((tl + (tc <<< 1) + tr) - (bl + (bc <<< 1) + br)) <<< 1;
         end
         default: begin
            gx_in = GRAD_W'((((tr + br) * 3 + mr * 10) - ((tl + bl) * 3 + ml * 10)) <<< 1);
            gy_in = GRAD_W'((((tl + tr) * 3 + tc * 10) - ((bl + br) * 3 + bc * 10)) <<< 1);
         end
      endcase
      // Fold the angle into the upper half plane.
      fx = (gy_ff < 0) ? -gx_ff : gx_ff;
      fy = (gy_ff < 0) ? -gy_ff : gy_ff;
      two = {1'b0, ax2_ff} << 1;
      near_axis = s2_ff < {1'b0, two};
      steep = c_gt_ff && ({1'b0, d2_ff} >= two);
      if (c_zero_ff || near_axis) begin
         bin = BIN_HORIZ;
      end else if (steep) begin
         bin = BIN_VERT;
      end else begin
         bin = c_neg_ff ? BIN_135 : BIN_45;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
      end else if (advance) begin
         a_valid_ff <= issue.valid;
         b_valid_ff <= a_valid_ff;
         c_valid_ff <= b_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         a_last_ff <= issue.last;
         gx_ff     <= gx_in;
         gy_ff     <= gy_in;

         b_last_ff <= a_last_ff;
         b_zero_ff <= (gx_ff == 0) && (gy_ff == 0);
         b_neg_ff  <= fx < 0;
         ax_ff     <= ABS_W'((fx < 0) ? -fx : fx);
         ay_ff     <= ABS_W'(fy);
         b_gt_ff   <= ((fx < 0) ? -fx : fx) < fy;
         s_ff      <= (ABS_W+1)'(fy) + (ABS_W+1)'((fx < 0) ? -fx : fx);
         d_ff      <= ABS_W'(fy - ((fx < 0) ? -fx : fx));

         c_last_ff <= b_last_ff;
         c_zero_ff <= b_zero_ff;
         c_neg_ff  <= b_neg_ff;
         c_gt_ff   <= b_gt_ff;
         ax2_ff    <= ax_ff * ax_ff;
         ay2_ff    <= ay_ff * ay_ff;
         d2_ff     <= d_ff * d_ff;
         s2_ff     <= s_ff * s_ff;

         head_ff.last <= c_last_ff;
         head_ff.dir  <= cfg.direction_enable ? bin : BIN_HORIZ;
         head_ff.rem  <= ax2_ff + ay2_ff;
         head_ff.res  <= '0;
      end
      if (reset) begin
         head_ff.valid <= 1'b0;
      end else if (advance) begin
         head_ff.valid <= c_valid_ff;
      end
   end

   assign head = head_ff;

endmodule

FILE: rtl/egd_root_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// egd_root_cell
// One bit-pair step of the restoring integer square root.
// ----------------------------------------------------------------------------
module egd_root_cell #(
   parameter int STEP = 0
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               advance,
   input  egd_pkg::cell_type  prev,
   output egd_pkg::cell_type  next
);
   import egd_pkg::*;

   localparam logic [SQ_W-1:0] TRIAL = SQ_W'(1) << (2 * (ROOT_STEPS - 1 - STEP));

   cell_type next_ff, next_in;
   logic [SQ_W-1:0] probe;

   always_comb begin
      next_in = prev;
      probe   = prev.res + TRIAL;
      if (prev.rem >= probe) begin
         next_in.rem = prev.rem - probe;
         next_in.res = (prev.res >> 1) + TRIAL;
      end else begin
         next_in.res = prev.res >> 1;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         next_ff.last <= next_in.last;
         next_ff.dir  <= next_in.dir;
         next_ff.rem  <= next_in.rem;
         next_ff.res  <= next_in.res;
      end
      if (reset) begin
         next_ff.valid <= 1'b0;
      end else if (advance) begin
         next_ff.valid <= prev.valid;
      end
   end

   assign next = next_ff;

endmodule

FILE: rtl/edge_gradient_direction.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// edge_gradient_direction
// 3x3 gradient magnitude and direction bin of a raster pixel stream.
// ----------------------------------------------------------------------------
// Pixels arrive on req_if, one per beat, in raster order. Each results beat on
// rsp_if carries a magnitude, a direction bin and a flag marking the last
// result caused by that pixel; a pixel causes between none and four results.
// Each pixel passes three steps in the line stores (accept, store read,
// window update) and then issues its results one after another while the
// chain advances; the next pixel is taken only after that. The store-read
// step exists for the registered read of the line store. A result passes
// four front stages, then one square root cell per result bit, to the output.
// When the receiver stalls, the whole chain holds, the sequencer stops
// issuing and no further pixel is taken until the current one has issued.
// Reset clears the counters, the window and the chain; the line stores are
// not cleared and hold valid data only after the first row has been written.
// Configuration is written through csr_* while the block is idle.
// ----------------------------------------------------------------------------
module edge_gradient_direction #(
   parameter int MAX_WIDTH = 4096
) (
   input  logic         clock,
   input  logic         reset,
   egd_req_if.sink      req_if,
   egd_rsp_if.source    rsp_if,
   input  logic         csr_write_enable,
   input  logic [1:0]   csr_index,
   input  logic [15:0]  csr_write_data
);
   import egd_pkg::*;

   cfg_type   cfg_ff;
   logic      advance;
   issue_type issue;
   win_type   window;
   cell_type  chain [ROOT_STEPS+1];

   // Register file: plain writes, no read-back.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.line_width        <= 13'd1024;
         cfg_ff.frame_height      <= 16'd768;
         cfg_ff.gradient_operator <= OP_SOBEL;
         cfg_ff.direction_enable  <= 1'b1;
      end else if (csr_write_enable) begin
         case (csr_index)
            REG_LINE_WIDTH:   cfg_ff.line_width        <= csr_write_data[12:0];
            REG_FRAME_HEIGHT: cfg_ff.frame_height      <= csr_write_data;
            REG_OPERATOR:     cfg_ff.gradient_operator <= csr_write_data[1:0];
            REG_DIR_ENABLE:   cfg_ff.direction_enable  <= csr_write_data[0];
            default: ;
         endcase
      end
   end

   // The chain moves whenever the output stage is empty or being taken.
   assign advance = !chain[ROOT_STEPS].valid || rsp_if.ready;

   egd_window #(.MAX_WIDTH(MAX_WIDTH)) u_window (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .in_valid (req_if.valid),
      .in_ready (req_if.ready),
      .in_pixel (req_if.pixel_value),
      .advance  (advance),
      .issue    (issue),
      .window   (window)
   );

   egd_front u_front (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .cfg     (cfg_ff),
      .issue   (issue),
      .window  (window),
      .head    (chain[0])
   );

   // One cell per result bit; each cell hands its partial root to the next.
   for (genvar i = 0; i < ROOT_STEPS; i++) begin : g_root
      egd_root_cell #(.STEP(i)) u_cell (
         .clock   (clock),
         .reset   (reset),
         .advance (advance),
         .prev    (chain[i]),
         .next    (chain[i+1])
      );
   end

   assign rsp_if.valid         = chain[ROOT_STEPS].valid;
   assign rsp_if.magnitude     = chain[ROOT_STEPS].res[MAG_W-1:0];
   assign rsp_if.direction_bin = chain[ROOT_STEPS].dir;
   assign rsp_if.last_in_run   = chain[ROOT_STEPS].last;

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench of the 3x3 gradient magnitude and direction block.
// ----------------------------------------------------------------------------
// Whole frames of pixels are queued by the stimulus process and offered by a
// clocked driver. Each accepted pixel beat is run through a behavioural copy
// of the line stores and window, and the results it causes are queued. A
// clocked monitor compares each result beat with the oldest queued one. The
// configuration is rewritten only at frame boundaries while the block is idle.
// ----------------------------------------------------------------------------
module tb_top;
   import egd_pkg::*;

   localparam int LINE_MAX     = 4096;
   localparam int DRAIN_CYCLES = 60;
   localparam int WATCHDOG     = 5000;
   localparam int HOLD_CYCLES  = 400;

   // Idling modes of the two sides.
   localparam int MODE_FREE  = 0;
   localparam int MODE_SEND  = 1;
   localparam int MODE_RECV  = 2;
   localparam int MODE_BOTH  = 3;

   typedef struct packed {
      logic [MAG_W-1:0] magnitude;
      logic [1:0]       direction_bin;
      logic             last_in_run;
   } grad_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic        csr_write_enable = 1'b0;
   logic [1:0]  csr_index        = REG_LINE_WIDTH;
   logic [15:0] csr_write_data   = '0;

   egd_req_if req_bus ();
   egd_rsp_if rsp_bus ();

   edge_gradient_direction dut (
      .clock            (clock),
      .reset            (reset),
      .req_if           (req_bus),
      .rsp_if           (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      req_bus.valid       = 1'b0;
      req_bus.pixel_value = '0;
      rsp_bus.ready       = 1'b0;
   end

   // Pixels waiting to be offered, and results waiting to be seen.
   logic [PIX_W-1:0] pixel_backlog[$];
   grad_result_type  pending_results[$];

   int idle_mode   = MODE_FREE;
   int errors      = 0;
   int pixels_in   = 0;
   int results_out = 0;
   bit hold_kick   = 1'b0;

   // ------------------------------------------------------------------------
   // Behavioural copy of the block: line stores, window, counters, settings.
   // ------------------------------------------------------------------------
   logic [PIX_W-1:0] store_older[LINE_MAX];
   logic [PIX_W-1:0] store_newer[LINE_MAX];
   logic [PIX_W-1:0] window_px[9];
   int unsigned      col_pos = 0;
   int unsigned      row_pos = 0;
   logic [12:0]      cfg_width = 13'd1024;
   logic [15:0]      cfg_height = 16'd768;
   logic [1:0]       cfg_op = OP_SOBEL;
   logic             cfg_dir = 1'b1;

   initial begin
      foreach (window_px[i]) window_px[i] = '0;
   end

   // The settings copy follows the write port at the same edges as the block.
   always @(posedge clock) begin
      if (!reset && csr_write_enable) begin
         case (csr_index)
            REG_LINE_WIDTH:   cfg_width  <= csr_write_data[12:0];
            REG_FRAME_HEIGHT: cfg_height <= csr_write_data;
            REG_OPERATOR:     cfg_op     <= csr_write_data[1:0];
            REG_DIR_ENABLE:   cfg_dir    <= csr_write_data[0];
            default: ;
         endcase
      end
   end

   function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned res = 0;
      longint unsigned bitv = 64'd1 << 62;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
         if (v >= res + bitv) begin
            v  -= res + bitv;
            res = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      return res;
   endfunction

   // Exact quantisation of the angle into four bins, all in integers.
   function automatic logic [1:0] angle_to_bin(longint gx, longint gy);
      longint unsigned ax, ay, two, s, d;
      bit neg, near_axis, steep;
      if (gx == 0 && gy == 0) return BIN_HORIZ;
      if (gy < 0) begin
         gx = -gx;
         gy = -gy;
      end
      neg = gx < 0;
      ax = neg ? -gx : gx;
      ay = gy;
      two = 2 * ax * ax;
      s = ay + ax;
      near_axis = s * s < two;
      d = ay - ax;
      steep = ay > ax && d * d >= two;
      if (near_axis) return BIN_HORIZ;
      if (steep) return BIN_VERT;
      return neg ? BIN_135 : BIN_45;
   endfunction

   // One gradient from the window. ra/rb/rc pick the top, middle and bottom
   // rows; cl/cr the left and right columns. When cl is the middle column the
   // right column stands in as the centre, which repeats the right border.
   function automatic grad_result_type gradient_at(int ra, int rb, int rc, int cl, int cr);
      longint tl, tr, t, l, r, bl, br, b, gx, gy;
      grad_result_type res;
      tl = window_px[ra*3+cl];
      tr = window_px[ra*3+cr];
      t  = window_px[ra*3+(cl == 1 ? 2 : 1)];
      l  = window_px[rb*3+cl];
      r  = window_px[rb*3+cr];
      bl = window_px[rc*3+cl];
      br = window_px[rc*3+cr];
      b  = window_px[rc*3+(cl == 1 ? 2 : 1)];
      case (cfg_op)
         OP_DIFF: begin
            gx = 2 * (r - l);
            gy = 2 * (t - b);
         end
         OP_PREWITT: begin
            gx = (tr + r + br) - (tl + l + bl);
            gy = (tl + t + tr) - (bl + b + br);
         end
         OP_SOBEL: begin
            gx = 2 * ((tr + 2*r + br) - (tl + 2*l + bl));
            gy = 2 * ((tl + 2*t + tr) - (bl + 2*b + br));
         end
         default: begin
            gx = 2 * ((3*tr + 10*r + 3*br) - (3*tl + 10*l + 3*bl));
            gy = 2 * ((3*tl + 10*t + 3*tr) - (3*bl + 10*b + 3*br));
         end
      endcase
      res.magnitude     = MAG_W'(int_sqrt(longint'(gx*gx) + longint'(gy*gy)));
      res.direction_bin = cfg_dir ? angle_to_bin(gx, gy) : BIN_HORIZ;
      res.last_in_run   = 1'b0;
      return res;
   endfunction

   // Advances the copy by one accepted pixel and queues what it produces.
   task automatic predict_gradients(logic [PIX_W-1:0] p);
      int unsigned w, h, x;
      bit at_end, last_row;
      logic [PIX_W-1:0] top, mid, v;
      grad_result_type batch[$];
      w = (cfg_width == 0) ? 1 : (cfg_width > LINE_MAX ? LINE_MAX : cfg_width);
      h = (cfg_height < 2) ? 2 : cfg_height;
      x = (col_pos >= LINE_MAX) ? LINE_MAX - 1 : col_pos;
      at_end = x >= w - 1;
      last_row = 1'b0;
      if (row_pos == 0) begin
         store_newer[x] = p;
      end else begin
         top = (row_pos == 1) ? store_newer[x] : store_older[x];
         mid = store_newer[x];
         store_older[x] = mid;
         store_newer[x] = p;
         for (int k = 0; k < 3; k++) begin
            v = (k == 0) ? top : (k == 1) ? mid : p;
            if (x == 0) begin
               window_px[k*3]   = v;
               window_px[k*3+1] = v;
            end else begin
               window_px[k*3]   = window_px[k*3+1];
               window_px[k*3+1] = window_px[k*3+2];
            end
            window_px[k*3+2] = v;
         end
         last_row = row_pos >= h - 1;
         if (x >= 1) batch.push_back(gradient_at(0, 1, 2, 0, 2));
         if (at_end) batch.push_back(gradient_at(0, 1, 2, 1, 2));
         if (last_row) begin
            // The bottom row repeats itself below the last image row.
            if (x >= 1) batch.push_back(gradient_at(1, 2, 2, 0, 2));
            if (at_end) batch.push_back(gradient_at(1, 2, 2, 1, 2));
         end
         if (batch.size() > 0) batch[batch.size()-1].last_in_run = 1'b1;
         foreach (batch[i]) pending_results.push_back(batch[i]);
      end
      if (at_end) begin
         col_pos = 0;
         row_pos = last_row ? 0 : ((row_pos + 1) & 16'hFFFF);
      end else begin
         col_pos = x + 1;
      end
   endtask

   // ------------------------------------------------------------------------
   // Driver: offers pixels from the backlog; a held beat stays put.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            predict_gradients(req_bus.pixel_value);
            pixels_in++;
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (pixel_backlog.size() > 0 &&
                !((idle_mode == MODE_SEND && $urandom_range(99) < 85) ||
                  (idle_mode == MODE_BOTH && $urandom_range(99) < 32))) begin
               req_bus.valid       <= 1'b1;
               req_bus.pixel_value <= pixel_backlog.pop_front();
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // Long receiver hold-off, counted here and started by a toggle of hold_kick.
   int hold_left = 0;
   bit hold_seen = 1'b0;
   always @(posedge clock) begin
      if (hold_kick != hold_seen) begin
         hold_seen <= hold_kick;
         hold_left <= HOLD_CYCLES;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // ------------------------------------------------------------------------
   // Monitor: checks each result beat against the oldest prediction.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      grad_result_type want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            results_out++;
            if (pending_results.size() == 0) begin
               errors++;
               if (errors <= 10)
                  $display("ERROR: unexpected result beat: mag %0d dir %0d last %0b",
                           rsp_bus.magnitude, rsp_bus.direction_bin,
                           rsp_bus.last_in_run);
            end else begin
               want = pending_results.pop_front();
               if (rsp_bus.magnitude !== want.magnitude ||
                   rsp_bus.direction_bin !== want.direction_bin ||
                   rsp_bus.last_in_run !== want.last_in_run) begin
                  errors++;
                  if (errors <= 10)
                     $display({"ERROR: result %0d: expected mag %0d dir %0d last %0b,",
                               " got mag %0d dir %0d last %0b"},
                              results_out, want.magnitude, want.direction_bin,
                              want.last_in_run, rsp_bus.magnitude,
                              rsp_bus.direction_bin, rsp_bus.last_in_run);
               end
            end
         end
         rsp_bus.ready <= !(hold_left > 0 ||
                            (idle_mode == MODE_RECV && $urandom_range(99) < 85) ||
                            (idle_mode == MODE_BOTH && $urandom_range(99) < 32));
      end
   end

   // Watchdog: too long without any beat on either channel ends the run.
   int quiet_cycles = 0;
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG) begin
         $display("Watchdog: no beat for %0d cycles, %0d results outstanding",
                  quiet_cycles, pending_results.size());
         $display("Simulation FAILED");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------------

   // Waits until everything offered has been taken and every result seen,
   // then lets the pipeline drain before the settings may change.
   task automatic wait_idle();
      forever begin
         @(posedge clock);
         #1;
         if (pixel_backlog.size() == 0 && !req_bus.valid && pending_results.size() == 0)
            break;
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_settings(int w, int h, logic [1:0] op, logic dir);
      csr_write_enable <= 1'b1;
      csr_index <= REG_LINE_WIDTH;   csr_write_data <= w[15:0];
      @(posedge clock);
      csr_index <= REG_FRAME_HEIGHT; csr_write_data <= h[15:0];
      @(posedge clock);
      csr_index <= REG_OPERATOR;     csr_write_data <= {14'd0, op};
      @(posedge clock);
      csr_index <= REG_DIR_ENABLE;   csr_write_data <= {15'd0, dir};
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   function automatic logic [PIX_W-1:0] random_pixel();
      case ($urandom_range(7))
         0: return '0;
         1: return '1;
         2: return PIX_W'($urandom_range(40));
         default: return PIX_W'($urandom);
      endcase
   endfunction

   // Queues one whole frame of random pixels at the effective size.
   task automatic queue_frame(int w, int h);
      int ew, eh;
      ew = (w == 0) ? 1 : (w > LINE_MAX ? LINE_MAX : w);
      eh = (h < 2) ? 2 : h;
      repeat (ew * eh) pixel_backlog.push_back(random_pixel());
   endtask

   task automatic queue_list(logic [PIX_W-1:0] px[$]);
      foreach (px[i]) pixel_backlog.push_back(px[i]);
   endtask

   int random_items;
   int fw, fh;

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      repeat (2) @(posedge clock);

      // Directed: 2x2 frames of extreme pixels under every operator.
      write_settings(2, 2, OP_DIFF, 1'b1);
      queue_list('{20'h00000, 20'hFFFFF, 20'h00000, 20'hFFFFF});
      wait_idle();
      write_settings(2, 2, OP_PREWITT, 1'b1);
      queue_list('{20'hFFFFF, 20'hFFFFF, 20'h00000, 20'h00000});
      wait_idle();
      write_settings(2, 2, OP_SOBEL, 1'b1);
      queue_list('{20'h00000, 20'hFFFFF, 20'hFFFFF, 20'h00000});
      wait_idle();
      write_settings(2, 2, OP_SCHARR, 1'b0);
      queue_list('{20'hFFFFF, 20'h00000, 20'h00000, 20'hFFFFF});
      wait_idle();
      // A flat image has no gradient, which must give the horizontal bin.
      write_settings(2, 2, OP_SCHARR, 1'b1);
      queue_list('{20'h12345, 20'h12345, 20'h12345, 20'h12345});
      wait_idle();
      // Width zero acts as one column and a height of one as two rows.
      write_settings(0, 1, OP_SOBEL, 1'b1);
      queue_list('{20'hFFFFF, 20'h00000});
      wait_idle();
      write_settings(1, 0, OP_PREWITT, 1'b1);
      queue_list('{20'h00001, 20'hFFFFE});
      wait_idle();

      // Random frames, mostly small, under each way of idling.
      random_items = 0;
      for (int ph = 0; ph < 8; ph++) begin
         idle_mode = ph % 4;
         fw = $urandom_range(8, 1);
         fh = $urandom_range(5, 2);
         write_settings(fw, fh, 2'($urandom), 1'($urandom));
         for (int n = 0; n < 28; n += fw * fh) begin
            queue_frame(fw, fh);
            random_items += fw * fh;
         end
         wait_idle();
      end

      // The receiver holds off for a long stretch while pixels keep coming.
      idle_mode = MODE_FREE;
      write_settings(8, 6, OP_SCHARR, 1'b1);
      queue_frame(8, 6);
      hold_kick = ~hold_kick;
      random_items += 48;
      wait_idle();

      $display("Covered %0d pixels (%0d in random frames) and %0d results,",
               pixels_in, random_items, results_out);
      $display("all four operators, both direction settings and every idling pattern.");
      if (errors == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("%0d mismatches", errors);
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
